>>> hw/rtl/sdk_pkg.sv
// Shared types and constants of the sidechain audio ducker.
// No dependencies; every other file of the block uses this package.
package sdk_pkg;

	// Field widths fixed by the frame and result formats.
	localparam int SDK_SAMPLE_BITS   = 16;
	localparam int SDK_PEAK_BITS     = 16;
	localparam int SDK_DEPTH_BITS    = 17;
	localparam int SDK_STEP_BITS     = 25;
	localparam int SDK_LEVEL_BITS    = 25;
	localparam int SDK_GAIN_BITS     = 17;
	localparam int SDK_REDUCE_BITS   = 18;
	localparam int SDK_CFG_IDX_BITS  = 4;
	localparam int SDK_CFG_DATA_BITS = 25;
	localparam int SDK_MAX_LANES     = 2;

	typedef logic signed [SDK_SAMPLE_BITS-1:0] sample_t;
	typedef logic [SDK_PEAK_BITS-1:0]          peak_t;
	typedef logic [SDK_DEPTH_BITS-1:0]         depth_t;
	typedef logic [SDK_STEP_BITS-1:0]          step_val_t;
	typedef logic [SDK_LEVEL_BITS-1:0]         level_t;
	typedef logic [SDK_GAIN_BITS-1:0]          gain_t;
	typedef logic [SDK_CFG_IDX_BITS-1:0]       cfg_idx_t;
	typedef logic [SDK_CFG_DATA_BITS-1:0]      cfg_data_t;

	// Fixed-point unity values and the floor below which ducking is released.
	localparam level_t LEVEL_ONE    = 25'h100_0000;
	localparam gain_t  GAIN_ONE     = 17'h1_0000;
	localparam depth_t DEPTH_ONE    = 17'h1_0000;
	localparam level_t ACTIVE_FLOOR = 25'd16778;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_THRESHOLD = 4'd0;
	localparam cfg_idx_t CFG_DEPTH     = 4'd1;
	localparam cfg_idx_t CFG_ATTACK    = 4'd2;
	localparam cfg_idx_t CFG_RELEASE   = 4'd3;

	// Register values after reset.
	localparam peak_t     RST_THRESHOLD = 16'd1036;
	localparam depth_t    RST_DEPTH     = 17'd32768;
	localparam step_val_t RST_ATTACK    = 25'd1271;
	localparam step_val_t RST_RELEASE   = 25'd763;

	// One-cycle strobes from the sequencer to the processing units.
	typedef struct packed {
		logic detect;
		logic ramp;
		logic reduce;
		logic gain;
	} sdk_step_t;

	// Outcome of the peak detection handed to the ramp unit.
	typedef struct packed {
		logic target;
		logic engage;
	} sdk_det_t;

endpackage

>>> hw/rtl/sdk_if.sv
// Valid/ready channel interfaces of the ducker: frame in, result out and register writes.
// Depends on sdk_pkg for the field types.
interface sdk_frame_if;
	logic             valid;
	logic             ready;
	sdk_pkg::sample_t narr_left;
	sdk_pkg::sample_t narr_right;
	sdk_pkg::sample_t music_left;
	sdk_pkg::sample_t music_right;
	logic             block_last;

	modport source (output valid, narr_left, narr_right, music_left, music_right, block_last,
		input ready);
	modport sink (input valid, narr_left, narr_right, music_left, music_right, block_last,
		output ready);
endinterface

interface sdk_result_if;
	logic             valid;
	logic             ready;
	sdk_pkg::sample_t out_left;
	sdk_pkg::sample_t out_right;
	sdk_pkg::level_t  level_now;
	sdk_pkg::gain_t   gain_now;
	logic             active_flag;

	modport source (output valid, out_left, out_right, level_now, gain_now, active_flag,
		input ready);
	modport sink (input valid, out_left, out_right, level_now, gain_now, active_flag,
		output ready);
endinterface

interface sdk_cfg_if;
	logic                 valid;
	logic                 ready;
	sdk_pkg::cfg_idx_t    index;
	sdk_pkg::cfg_data_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sdk_lane.sv
// One channel lane: holds the frame's samples, finds the narration magnitude
// and scales the music sample by the gain. Depends on sdk_pkg.
module sdk_lane (
	input  logic             clk,
	input  logic             load,
	input  sdk_pkg::sample_t narr_in,
	input  sdk_pkg::sample_t music_in,
	input  sdk_pkg::gain_t   gain,
	output sdk_pkg::peak_t   mag,
	output sdk_pkg::sample_t scaled
);
	import sdk_pkg::*;

	localparam int PROD_BITS = SDK_SAMPLE_BITS + SDK_GAIN_BITS;

	sample_t                    narr_q;
	sample_t                    music_q;
	logic [SDK_SAMPLE_BITS-1:0] narr_u;
	logic [SDK_SAMPLE_BITS-1:0] music_u;
	logic [SDK_SAMPLE_BITS-1:0] music_mag;
	logic [PROD_BITS-1:0]       prod;
	logic [SDK_SAMPLE_BITS-1:0] prod_top;

	// Capture the samples of the accepted beat.
	always_ff @(posedge clk) begin
		if (load) begin
			narr_q  <= narr_in;
			music_q <= music_in;
		end
	end

	// Magnitudes; the most negative sample maps to its exact magnitude.
	assign narr_u    = narr_q;
	assign music_u   = music_q;
	assign mag       = narr_u[SDK_SAMPLE_BITS-1] ? (~narr_u + 1'b1) : narr_u;
	assign music_mag = music_u[SDK_SAMPLE_BITS-1] ? (~music_u + 1'b1) : music_u;

	// Scale the magnitude, then restore the sign: truncation toward zero.
	assign prod     = PROD_BITS'(music_mag) * PROD_BITS'(gain);
	assign prod_top = prod[SDK_GAIN_BITS - 1 + SDK_SAMPLE_BITS - 1 -: SDK_SAMPLE_BITS];
	assign scaled   = music_u[SDK_SAMPLE_BITS-1] ? sample_t'(~prod_top + 1'b1)
		: sample_t'(prod_top);

endmodule

>>> hw/rtl/sdk_merge.sv
// Merging stage: combines the lane magnitudes into the block peak and decides
// the duck target at the end of each analysis block. Depends on sdk_pkg.
module sdk_merge #(
	parameter int LANES = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              detect,
	input  logic              block_last,
	input  sdk_pkg::peak_t    threshold,
	input  sdk_pkg::peak_t    lane_mag [LANES],
	output sdk_pkg::sdk_det_t det
);
	import sdk_pkg::*;

	peak_t block_peak_q;
	logic  target_q;
	peak_t peak;
	logic  over;

	// Running peak over the stored block peak and every lane.
	always_comb begin
		peak = block_peak_q;
		for (int ln = 0; ln < LANES; ln++) begin
			if (lane_mag[ln] > peak) begin
				peak = lane_mag[ln];
			end
		end
	end

	// A peak equal to the threshold does not duck.
	assign over = peak > threshold;

	// Block peak updates once per frame; the target only on the last frame of a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_peak_q <= '0;
			target_q     <= 1'b0;
		end else if (detect) begin
			if (block_last) begin
				target_q     <= over;
				block_peak_q <= '0;
			end else begin
				block_peak_q <= peak;
			end
		end
	end

	assign det.target = target_q;
	assign det.engage = block_last && over;

endmodule

>>> hw/rtl/sdk_ramp.sv
// Duck level ramp and gain unit: steps the level toward the target, forms the
// gain from level and depth, and keeps the active flag. Depends on sdk_pkg.
module sdk_ramp (
	input  logic               clk,
	input  logic               arst_n,
	input  sdk_pkg::sdk_step_t step,
	input  sdk_pkg::sdk_det_t  det,
	input  sdk_pkg::step_val_t attack,
	input  sdk_pkg::step_val_t release_step,
	input  sdk_pkg::depth_t    depth,
	output sdk_pkg::level_t    level,
	output sdk_pkg::gain_t     gain,
	output logic               active
);
	import sdk_pkg::*;

	localparam int PROD_BITS = SDK_LEVEL_BITS + SDK_DEPTH_BITS;

	level_t                     level_q;
	logic                       active_q;
	logic [SDK_REDUCE_BITS-1:0] reduction_q;
	gain_t                      gain_q;
	level_t                     level_c;
	level_t                     level_next;
	logic [SDK_LEVEL_BITS:0]    level_sum;
	depth_t                     depth_c;
	logic [PROD_BITS-1:0]       prod;

	// Linear step toward the target, clamped at the target.
	always_comb begin
		level_c   = (level_q > LEVEL_ONE) ? LEVEL_ONE : level_q;
		level_sum = {1'b0, level_c} + {1'b0, attack};
		if (det.target) begin
			if (level_c < LEVEL_ONE) begin
				level_next = (level_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE
					: level_sum[SDK_LEVEL_BITS-1:0];
			end else begin
				level_next = level_c;
			end
		end else begin
			level_next = (level_c > release_step) ? (level_c - release_step) : '0;
		end
	end

	// Reduction is level times depth, floored to Q2.16.
	assign depth_c = (depth > DEPTH_ONE) ? DEPTH_ONE : depth;
	assign prod    = PROD_BITS'(level_q) * PROD_BITS'(depth_c);

	// Level, active flag, reduction and gain, each on its own strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			active_q <= 1'b0;
		end else begin
			if (step.detect && det.engage) begin
				active_q <= 1'b1;
			end
			if (step.ramp) begin
				level_q <= level_next;
				if (level_next < ACTIVE_FLOOR && !det.target) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.reduce) begin
			reduction_q <= prod[PROD_BITS-1 -: SDK_REDUCE_BITS];
		end
		if (step.gain) begin
			gain_q <= (reduction_q >= SDK_REDUCE_BITS'(GAIN_ONE)) ? '0
				: GAIN_ONE - SDK_GAIN_BITS'(reduction_q);
		end
	end

	assign level  = level_q;
	assign gain   = gain_q;
	assign active = active_q;

endmodule

>>> hw/rtl/sidechain_audio_ducker.sv
// Sidechain audio ducker. Takes one stereo frame (narration and music samples)
// per beat and returns one result beat holding the ducked music samples, the
// duck level, the applied gain and the active flag. A frame passes from acceptance
// to the result register through the five-step sequencer (detect, ramp, reduce,
// gain, scale), which serves one frame at a time and holds in scale while the
// result register is still full and not taken. A new frame is taken in the cycle
// after the previous one has reached the result register. Registers are written
// through the cfg channel, which is always ready, and should be changed only
// while no frame is in work.
module sidechain_audio_ducker #(
	parameter int CHANNELS = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	sdk_frame_if.sink   samples,
	sdk_result_if.source ducked,
	sdk_cfg_if.sink     cfg
);
	import sdk_pkg::*;

	localparam int LANES = (CHANNELS >= 2) ? 2 : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DETECT = 3'd1;
	localparam logic [2:0] ST_RAMP   = 3'd2;
	localparam logic [2:0] ST_REDUCE = 3'd3;
	localparam logic [2:0] ST_GAIN   = 3'd4;
	localparam logic [2:0] ST_SCALE  = 3'd5;

	logic [2:0] state_q;
	logic       block_last_q;
	peak_t      threshold_q;
	depth_t     depth_q;
	step_val_t  attack_q;
	step_val_t  release_q;
	logic       accept;
	logic       out_free;
	logic       out_load;
	sdk_step_t  step;
	sdk_det_t   det;
	level_t     level;
	gain_t      gain;
	logic       active;
	peak_t      lane_mag [LANES];
	sample_t    lane_out [SDK_MAX_LANES];

	logic       out_valid_q;
	sample_t    out_left_q;
	sample_t    out_right_q;
	level_t     level_now_q;
	gain_t      gain_now_q;
	logic       active_q;

	// Configuration writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= RST_THRESHOLD;
			depth_q     <= RST_DEPTH;
			attack_q    <= RST_ATTACK;
			release_q   <= RST_RELEASE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_THRESHOLD: threshold_q <= cfg.data[SDK_PEAK_BITS-1:0];
				CFG_DEPTH:     depth_q     <= cfg.data[SDK_DEPTH_BITS-1:0];
				CFG_ATTACK:    attack_q    <= cfg.data[SDK_STEP_BITS-1:0];
				CFG_RELEASE:   release_q   <= cfg.data[SDK_STEP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Frame sequencer: one frame in work at a time.
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || ducked.ready;
	assign out_load      = (state_q == ST_SCALE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   state_q <= accept ? ST_DETECT : ST_IDLE;
				ST_DETECT: state_q <= ST_RAMP;
				ST_RAMP:   state_q <= ST_REDUCE;
				ST_REDUCE: state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_SCALE;
				ST_SCALE:  state_q <= out_free ? ST_IDLE : ST_SCALE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_last_q <= samples.block_last;
		end
	end

	assign step.detect = (state_q == ST_DETECT);
	assign step.ramp   = (state_q == ST_RAMP);
	assign step.reduce = (state_q == ST_REDUCE);
	assign step.gain   = (state_q == ST_GAIN);

	// Channel lanes; a missing right channel yields a zero output.
	for (genvar ch = 0; ch < SDK_MAX_LANES; ch++) begin : g_lane
		if (ch < LANES) begin : g_on
			sdk_lane u_lane (
				.clk      (clk),
				.load     (accept),
				.narr_in  ((ch == 0) ? samples.narr_left : samples.narr_right),
				.music_in ((ch == 0) ? samples.music_left : samples.music_right),
				.gain     (gain),
				.mag      (lane_mag[ch]),
				.scaled   (lane_out[ch])
			);
		end else begin : g_off
			assign lane_out[ch] = '0;
		end
	end

	sdk_merge #(
		.LANES (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.detect     (step.detect),
		.block_last (block_last_q),
		.threshold  (threshold_q),
		.lane_mag   (lane_mag),
		.det        (det)
	);

	sdk_ramp u_ramp (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.det          (det),
		.attack       (attack_q),
		.release_step (release_q),
		.depth        (depth_q),
		.level        (level),
		.gain         (gain),
		.active       (active)
	);

	// Result register parts the sequencer from the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (ducked.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= lane_out[0];
			out_right_q <= lane_out[1];
			level_now_q <= level;
			gain_now_q  <= gain;
			active_q    <= active;
		end
	end

	assign ducked.valid       = out_valid_q;
	assign ducked.out_left    = out_left_q;
	assign ducked.out_right   = out_right_q;
	assign ducked.level_now   = level_now_q;
	assign ducked.gain_now    = gain_now_q;
	assign ducked.active_flag = active_q;

endmodule

>>> hw/rtl/sdk_checker.sv
// Port-level checks of the sidechain audio ducker, bound to the top level.
// Depends on sdk_pkg and on the top level's channel interfaces.
module sdk_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input sdk_pkg::sample_t out_left,
	input sdk_pkg::sample_t out_right,
	input sdk_pkg::level_t  level_now,
	input sdk_pkg::gain_t   gain_now,
	input logic             active_flag
);
	import sdk_pkg::*;

	// Only one frame is in work: an accepted beat closes the input side.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a frame was in work");

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
			&& $stable(level_now) && $stable(gain_now) && $stable(active_flag))
		else $error("stalled result beat changed");

	// Level and gain never exceed unity, and a zero level leaves the music at unity gain.
	a_level_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_now <= LEVEL_ONE && gain_now <= GAIN_ONE
			&& (level_now != '0 || gain_now == GAIN_ONE))
		else $error("level or gain out of range");

	// A level at or above the release floor only exists while ducking is engaged.
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_now >= ACTIVE_FLOOR |-> active_flag)
		else $error("active flag low with the level above the floor");

endmodule

bind sidechain_audio_ducker sdk_checker u_sdk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (ducked.valid),
	.out_ready   (ducked.ready),
	.out_left    (ducked.out_left),
	.out_right   (ducked.out_right),
	.level_now   (ducked.level_now),
	.gain_now    (ducked.gain_now),
	.active_flag (ducked.active_flag)
);

>>> tb/sv/tb_sidechain_audio_ducker.sv
// Self-checking testbench of sidechain_audio_ducker: directed frames, register extremes and
// random narration blocks, each result compared against an in-bench model of the ducker.
// Depends on sdk_pkg, the sdk_if interfaces and the sidechain_audio_ducker top level.
module tb_sidechain_audio_ducker;
	import sdk_pkg::*;

	localparam int NUM_CH        = 2;
	localparam int PERIOD        = 12;
	localparam int RST_CYCLES    = 9;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int RAND_FRAMES   = 1880;
	localparam int RAND_PHASES   = 8;

	typedef struct {
		sample_t narr_l, narr_r, mus_l, mus_r;
		logic    last;
	} frame_t;

	typedef struct {
		sample_t left;
		sample_t right;
		level_t  level;
		gain_t   gain;
		logic    active;
	} duck_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sdk_frame_if  samples();
	sdk_result_if ducked();
	sdk_cfg_if    cfg();

	sidechain_audio_ducker #(.CHANNELS(NUM_CH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.ducked (ducked),
		.cfg    (cfg)
	);

	// Model state and register copies.
	level_t    duck_lvl;
	logic      duck_tgt;
	peak_t     blk_peak;
	logic      duck_on;
	peak_t     thr_reg;
	depth_t    depth_reg;
	step_val_t atk_reg;
	step_val_t rel_reg;

	duck_result_t ducked_due[$];
	int errors;
	int frames_sent;
	int regs_written;
	int results_seen;
	int engaged_seen;
	bit calm;

	always #(PERIOD / 2) clk = ~clk;

	function automatic longint unsigned sample_mag(sample_t s);
		int v;
		v = s;
		return (v < 0) ? -v : v;
	endfunction

	// Scale by the gain on the magnitude, so that the product truncates toward zero.
	function automatic sample_t scale_sample(sample_t s, longint unsigned g);
		int v;
		longint unsigned m, p;
		v = s;
		m = (v < 0) ? -v : v;
		p = (m * g) >> 16;
		if (v < 0)
			p = -p;
		return sample_t'(p);
	endfunction

	// One frame through the ducker: peak, block decision, ramp, gain and scaling.
	function automatic duck_result_t duck_frame(frame_t f);
		longint unsigned pk, m, lvl, dep, red, gn;
		duck_result_t r;
		pk = blk_peak;
		m = sample_mag(f.narr_l);
		if (m > pk)
			pk = m;
		if (NUM_CH >= 2) begin
			m = sample_mag(f.narr_r);
			if (m > pk)
				pk = m;
		end
		pk &= 16'hFFFF;
		if (f.last) begin
			if (pk > thr_reg) begin
				duck_tgt = 1'b1;
				duck_on = 1'b1;
			end else begin
				duck_tgt = 1'b0;
			end
			blk_peak = '0;
		end else begin
			blk_peak = peak_t'(pk);
		end

		lvl = duck_lvl;
		if (lvl > LEVEL_ONE)
			lvl = LEVEL_ONE;
		if (duck_tgt) begin
			if (lvl < LEVEL_ONE) begin
				lvl += atk_reg;
				if (lvl > LEVEL_ONE)
					lvl = LEVEL_ONE;
			end
		end else begin
			lvl = (lvl > rel_reg) ? lvl - rel_reg : 0;
		end
		duck_lvl = level_t'(lvl);

		dep = (depth_reg > DEPTH_ONE) ? DEPTH_ONE : depth_reg;
		red = (lvl * dep) >> 24;
		gn = (red >= GAIN_ONE) ? 0 : GAIN_ONE - red;
		if (lvl < ACTIVE_FLOOR && !duck_tgt)
			duck_on = 1'b0;

		r.left = scale_sample(f.mus_l, gn);
		r.right = (NUM_CH >= 2) ? scale_sample(f.mus_r, gn) : sample_t'(0);
		r.level = level_t'(lvl);
		r.gain = gain_t'(gn);
		r.active = duck_on;
		return r;
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, cfg_data_t d);
		case (idx)
			CFG_THRESHOLD: thr_reg = peak_t'(d);
			CFG_DEPTH:     depth_reg = depth_t'(d);
			CFG_ATTACK:    atk_reg = step_val_t'(d);
			CFG_RELEASE:   rel_reg = step_val_t'(d);
			default: ;
		endcase
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// A sample of random sign whose magnitude lies in [lo, hi].
	function automatic sample_t rand_mag(int unsigned lo, int unsigned hi);
		int unsigned m;
		m = $urandom_range(hi, lo);
		if (m >= 32768)
			return sample_t'(-32768);
		if ($urandom_range(1))
			return sample_t'(-int'(m));
		return sample_t'(m);
	endfunction

	function automatic frame_t mk(int nl, int nr, int ml, int mr, logic last);
		frame_t f;
		f.narr_l = sample_t'(nl);
		f.narr_r = sample_t'(nr);
		f.mus_l = sample_t'(ml);
		f.mus_r = sample_t'(mr);
		f.last = last;
		return f;
	endfunction

	// Send one frame beat; valid stays high when the next frame follows without a gap.
	task automatic push_frame(frame_t f);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.narr_left <= f.narr_l;
		samples.narr_right <= f.narr_r;
		samples.music_left <= f.mus_l;
		samples.music_right <= f.mus_r;
		samples.block_last <= f.last;
		do @(posedge clk); while (samples.ready !== 1'b1);
		ducked_due.push_back(duck_frame(f));
		frames_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain();
		int unsigned waited;
		samples.valid <= 1'b0;
		waited = 0;
		while (ducked_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (ducked_due.size() != 0) begin
			$error("%0d expected results never arrived", ducked_due.size());
			errors += ducked_due.size();
			ducked_due.delete();
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		apply_reg(idx, d);
		regs_written++;
		@(negedge clk);
	endtask

	// Registers change only once the block has gone idle.
	task automatic write_regs(cfg_data_t thr, cfg_data_t dep, cfg_data_t atk, cfg_data_t rel);
		drain();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_DEPTH, dep);
		write_reg(CFG_ATTACK, atk);
		write_reg(CFG_RELEASE, rel);
		cfg.valid <= 1'b0;
	endtask

	// Reset values: peak at and just over the threshold, full-scale samples.
	task automatic test_reset_defaults();
		push_frame(mk(RST_THRESHOLD, -RST_THRESHOLD, 32767, -32768, 1'b1));
		push_frame(mk(0, -1, -1, 0, 1'b0));
		push_frame(mk(-(RST_THRESHOLD + 1), 0, 1, -1, 1'b1));
		push_frame(mk(-32768, 32767, -32768, 32767, 1'b0));
		push_frame(mk(32767, -32768, 32767, -32768, 1'b0));
		push_frame(mk(0, 0, 12345, -12345, 1'b1));
		push_frame(mk(5, -5, -32768, 32767, 1'b1));
	endtask

	// Zero threshold, depth above one, full and zero steps.
	task automatic test_register_extremes();
		write_regs('0, cfg_data_t'({SDK_DEPTH_BITS{1'b1}}), '1, '1);
		push_frame(mk(1, 0, 32767, -32768, 1'b1));
		push_frame(mk(0, 0, -1, 1, 1'b0));
		push_frame(mk(0, 0, 20000, -20000, 1'b1));
		write_regs(RST_THRESHOLD, DEPTH_ONE, '0, '0);
		push_frame(mk(-32768, 0, 32767, -32768, 1'b1));
		push_frame(mk(10, 10, 32767, -32768, 1'b1));
		write_regs(RST_THRESHOLD, DEPTH_ONE - 1, LEVEL_ONE, cfg_data_t'(1));
		push_frame(mk(0, 32767, 32767, -32768, 1'b1));
		push_frame(mk(0, 0, 32767, -32768, 1'b1));
		push_frame(mk(0, 0, -32768, 32767, 1'b0));
	endtask

	// One analysis block: mostly well formed, sometimes with block_last scattered at random.
	task automatic send_block();
		int unsigned len, hot, cap;
		logic loud, scatter;
		frame_t f;
		len = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
		loud = logic'($urandom_range(1));
		scatter = ($urandom_range(9) == 0);
		cap = (thr_reg > 32767) ? 32767 : thr_reg;
		hot = $urandom_range(len - 1);
		for (int unsigned i = 0; i < len; i++) begin
			f.mus_l = sample_t'($urandom);
			f.mus_r = sample_t'($urandom);
			if (loud) begin
				f.narr_l = sample_t'($urandom);
				f.narr_r = sample_t'($urandom);
				if (i == hot && thr_reg < 32768) begin
					if ($urandom_range(1))
						f.narr_l = rand_mag(thr_reg + 1, 32768);
					else
						f.narr_r = rand_mag(thr_reg + 1, 32768);
				end
			end else begin
				f.narr_l = rand_mag(0, cap);
				f.narr_r = rand_mag(0, cap);
				if (i == hot)
					f.narr_l = rand_mag(cap, cap);
			end
			f.last = scatter ? logic'($urandom_range(1)) : (i == len - 1);
			push_frame(f);
		end
	endtask

	// Phases of random blocks, each under its own register setting.
	task automatic test_random_phases();
		int phase_end;
		cfg_data_t thr, dep, atk, rel;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					thr = RST_THRESHOLD;
					dep = RST_DEPTH;
					atk = RST_ATTACK;
					rel = RST_RELEASE;
				end
				1: begin
					thr = '0;
					dep = cfg_data_t'({SDK_DEPTH_BITS{1'b1}});
					atk = '1;
					rel = '1;
				end
				2: begin
					thr = cfg_data_t'(32768);
					dep = '0;
					atk = cfg_data_t'(1);
					rel = cfg_data_t'(1);
				end
				default: begin
					thr = cfg_data_t'(($urandom_range(4) == 0) ? $urandom_range(65535)
						: $urandom_range(6000));
					dep = cfg_data_t'(($urandom_range(3) == 0) ? DEPTH_ONE
						: $urandom_range(131071));
					atk = cfg_data_t'(($urandom_range(7) == 0) ? 0
						: LEVEL_ONE / $urandom_range(64, 1));
					rel = cfg_data_t'(($urandom_range(7) == 0) ? 0
						: LEVEL_ONE / $urandom_range(64, 1));
				end
			endcase
			write_regs(thr, dep, atk, rel);
			calm = (p == 3 || p == 6);
			phase_end = frames_sent + RAND_FRAMES / RAND_PHASES;
			while (frames_sent < phase_end)
				send_block();
			drain();
			calm = 1'b0;
		end
	endtask

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		duck_result_t want;
		if (arst_n === 1'b1 && ducked.valid === 1'b1 && ducked.ready === 1'b1) begin
			results_seen++;
			if (ducked.active_flag === 1'b1)
				engaged_seen++;
			if (ducked_due.size() == 0) begin
				$error("result beat with no frame outstanding");
				errors++;
			end else begin
				want = ducked_due.pop_front();
				check_field("out_left", want.left, ducked.out_left);
				check_field("out_right", want.right, ducked.out_right);
				check_field("level_now", want.level, ducked.level_now);
				check_field("gain_now", want.gain, ducked.gain_now);
				check_field("active_flag", want.active, ducked.active_flag);
			end
		end
	end

	// Result side back-pressure: runs of ready high broken by stalls of random length.
	initial begin
		int unsigned run;
		logic rdy;
		ducked.ready = 1'b0;
		run = 0;
		rdy = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (calm) begin
				rdy = 1'b1;
				run = 0;
			end else if (run == 0) begin
				if ($urandom_range(2) != 0) begin
					rdy = 1'b1;
					run = $urandom_range(16, 1);
				end else begin
					rdy = 1'b0;
					run = pick_gap();
					if (run == 0)
						run = 1;
				end
			end else begin
				run--;
			end
			ducked.ready <= rdy;
		end
	end

	// Run limit.
	initial begin
		#(LIMIT_CYCLES * PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.narr_left = '0;
		samples.narr_right = '0;
		samples.music_left = '0;
		samples.music_right = '0;
		samples.block_last = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_THRESHOLD;
		cfg.data = '0;
		errors = 0;
		frames_sent = 0;
		regs_written = 0;
		results_seen = 0;
		engaged_seen = 0;
		calm = 1'b0;
		duck_lvl = '0;
		duck_tgt = 1'b0;
		blk_peak = '0;
		duck_on = 1'b0;
		thr_reg = RST_THRESHOLD;
		depth_reg = RST_DEPTH;
		atk_reg = RST_ATTACK;
		rel_reg = RST_RELEASE;

		repeat (RST_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_phases();
		drain();

		$display("Sent %0d frames and %0d register writes; %0d results checked, %0d while ducking.",
			frames_sent, regs_written, results_seen, engaged_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
